// File: rtl/core/nbf_pkg.sv
package nbf_pkg;

  // pixel and window geometry
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int SUM_W = 12;
  localparam int CWT_W = 5;
  localparam int NUM_TAPS = 8;

  typedef logic [PIX_W-1:0] pix_t;
  // window row: element 0 is the newest (rightmost) column
  typedef pix_t [4:0] win_row_t;
  // window rows: 0 above, 1 centre, 2 below
  typedef win_row_t [2:0] win_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RECIPE = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // tap recipes
  typedef enum logic [2:0] {
    RCP_CROSS_STITCH = 3'd0,
    RCP_NORTH_PULL   = 3'd1,
    RCP_SCANLINE     = 3'd2,
    RCP_HALO         = 3'd3,
    RCP_STUTTER_STEP = 3'd4
  } recipe_t;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [1:0] dy;
    logic [2:0]        wt;
  } tap_t;

  // line store / window control from the pipeline sequencer
  typedef struct packed {
    logic s1_en;
    logic s1_valid;
    logic shift_en;
  } lw_ctrl_t;

  function automatic tap_t mk_tap(int dx, int dy, int wt);
    tap_t t;
    t.dx = 3'(dx);
    t.dy = 2'(dy);
    t.wt = 3'(wt);
    return t;
  endfunction

  // fixed tap table, weights in sixteenths; unused slots carry zero weight
  function automatic tap_t recipe_tap(recipe_t sel, logic [2:0] idx);
    tap_t t;
    t = '0;
    case (sel)
      RCP_NORTH_PULL: begin
        case (idx)
          3'd0: t = mk_tap(0, -1, 4);
          3'd1: t = mk_tap(-1, -1, 2);
          3'd2: t = mk_tap(1, -1, 2);
          3'd3: t = mk_tap(-1, 0, 1);
          3'd4: t = mk_tap(1, 0, 1);
          3'd5: t = mk_tap(0, 1, 1);
          default: t = '0;
        endcase
      end
      RCP_SCANLINE: begin
        case (idx)
          3'd0: t = mk_tap(-1, 0, 4);
          3'd1: t = mk_tap(1, 0, 4);
          3'd2: t = mk_tap(0, -1, 1);
          3'd3: t = mk_tap(0, 1, 1);
          3'd4: t = mk_tap(-2, 0, 1);
          3'd5: t = mk_tap(2, 0, 1);
          default: t = '0;
        endcase
      end
      RCP_HALO: begin
        case (idx)
          3'd0: t = mk_tap(-1, -1, 2);
          3'd1: t = mk_tap(1, -1, 2);
          3'd2: t = mk_tap(-1, 1, 2);
          3'd3: t = mk_tap(1, 1, 2);
          3'd4: t = mk_tap(-1, 0, 1);
          3'd5: t = mk_tap(1, 0, 1);
          3'd6: t = mk_tap(0, -1, 1);
          default: t = mk_tap(0, 1, 1);
        endcase
      end
      RCP_STUTTER_STEP: begin
        case (idx)
          3'd0: t = mk_tap(1, 0, 4);
          3'd1: t = mk_tap(1, 1, 2);
          3'd2: t = mk_tap(0, 1, 2);
          3'd3: t = mk_tap(-1, 0, 1);
          3'd4: t = mk_tap(0, -1, 1);
          3'd5: t = mk_tap(-1, -1, 1);
          default: t = '0;
        endcase
      end
      default: begin
        case (idx)
          3'd0: t = mk_tap(-1, 0, 2);
          3'd1: t = mk_tap(1, 0, 2);
          3'd2: t = mk_tap(0, -1, 2);
          3'd3: t = mk_tap(0, 1, 2);
          3'd4: t = mk_tap(-1, -1, 1);
          3'd5: t = mk_tap(1, -1, 1);
          3'd6: t = mk_tap(-1, 1, 1);
          default: t = mk_tap(1, 1, 1);
        endcase
      end
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/nbf_line_window.sv
module nbf_line_window
  import nbf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  lw_ctrl_t      ctrl,
  input  logic [CW-1:0] rd_addr,
  input  pix_t          pix_in,
  output win_t          win
);

  // two line stores, one entry per column
  pix_t mem_mid [MAX_WIDTH];
  pix_t mem_top [MAX_WIDTH];

  pix_t          s1_pix_r;
  pix_t          rd_mid_r;
  pix_t          rd_top_r;
  pix_t          fwd_mid_r;
  pix_t          fwd_top_r;
  logic          fwd_r;
  logic [CW-1:0] s1_col_r;
  pix_t          s1_mid;
  pix_t          s1_top;
  win_t          win_r;

  // read data, or the beat being written back to the same column
  assign s1_mid = fwd_r ? fwd_mid_r : rd_mid_r;
  assign s1_top = fwd_r ? fwd_top_r : rd_top_r;

  // write back: new pixel into the middle store, old middle into the upper store
  always_ff @(posedge clk) begin
    if (ctrl.s1_valid) begin
      mem_mid[s1_col_r] <= s1_pix_r;
      mem_top[s1_col_r] <= s1_mid;
    end
  end

  // read stage with forwarding from the pending write
  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      rd_mid_r  <= mem_mid[rd_addr];
      rd_top_r  <= mem_top[rd_addr];
      fwd_r     <= ctrl.s1_valid && (s1_col_r == rd_addr);
      fwd_mid_r <= s1_pix_r;
      fwd_top_r <= s1_mid;
      s1_pix_r  <= pix_in;
      s1_col_r  <= rd_addr;
    end
  end

  // 3x5 window shift
  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      win_r[0] <= {win_r[0][3:0], s1_top};
      win_r[1] <= {win_r[1][3:0], s1_mid};
      win_r[2] <= {win_r[2][3:0], s1_pix_r};
    end
  end

  assign win = win_r;

endmodule

// File: rtl/core/neighbourhood_blend_filter_top.sv
// Weighted 3x5 neighbourhood filter for a raster-order BGR pixel stream.
// Input beats carry one pixel in in_tdata; in_tuser high marks a drain beat
// sent after the last pixel of a frame. Output beats carry one filtered pixel,
// with out_tlast on the last pixel of the frame. The output for pixel k is
// produced by input beat k + width + 2, so width + 2 drain beats (or extra
// pixels) finish a frame; drain beats that arrive mid-frame are dropped.
// Throughput is one beat per clock while the receiver does not stall: each
// line store does one read and one write per beat, with forwarding when
// consecutive beats hit the same column. The pipeline has four registered
// stages with per-stage valids, so when the receiver stalls the input keeps
// accepting until the stages fill, then in_tready drops; nothing is lost or
// repeated. Reset clears the pipeline and frame counters and loads recipe 0
// and a 640x480 frame; the line stores need no clearing. Configuration goes
// through the APB port while the stream is idle; writing width or height
// restarts the frame.
module neighbourhood_blend_filter_top
  import nbf_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // blue, green, red
  input  logic        in_tuser,    // flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // blue, green, red
  output logic        out_tlast,   // frame_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HH = $clog2(MAX_HEIGHT + 1);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int LW = WW + 1;

  function automatic logic [WW-1:0] eff_w(logic [11:0] v);
    if (v == 12'd0) return WW'(1);
    if (32'(v) > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HH-1:0] eff_h(logic [11:0] v);
    if (v == 12'd0) return HH'(1);
    if (32'(v) > 32'(MAX_HEIGHT)) return HH'(MAX_HEIGHT);
    return HH'(v);
  endfunction

  // configuration registers
  logic [2:0]  recipe_r;
  logic [11:0] width_r;
  logic [11:0] height_r;
  logic        cfg_wr;
  logic        size_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign size_wr    = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recipe_r <= 3'(RCP_CROSS_STITCH);
      width_r  <= 12'd640;
      height_r <= 12'd480;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RECIPE: recipe_r <= cfg_pwdata[2:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[11:0];
        REG_HEIGHT: height_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_RECIPE: cfg_prdata = {29'd0, recipe_r};
      REG_WIDTH:  cfg_prdata = {20'd0, width_r};
      REG_HEIGHT: cfg_prdata = {20'd0, height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  logic [WW-1:0] w_eff;
  logic [HH-1:0] h_eff;
  recipe_t       rsel;

  assign w_eff = eff_w(width_r);
  assign h_eff = eff_h(height_r);
  assign rsel  = (recipe_r <= 3'd4) ? recipe_t'(recipe_r) : RCP_CROSS_STITCH;

  // pipeline handshake
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic o_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_fire;

  assign o_rdy     = !out_v_r || out_tready;
  assign s3_rdy    = !s3_v_r || o_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_fire   = in_tvalid && in_tready;

  // frame position counters
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HH-1:0] in_row_r, in_row_nxt;
  logic [LW-1:0] lag_r, lag_nxt;
  logic [CW-1:0] kx_r, kx_nxt;
  logic [HW-1:0] ky_r, ky_nxt;
  logic          late, processed, col_last, lag_full, kx_last, ky_last, fend;

  assign late      = (in_row_r >= h_eff);
  assign processed = in_fire && (!in_tuser || late);
  assign col_last  = (WW'(in_col_r) == w_eff - WW'(1));
  assign lag_full  = (lag_r == LW'(w_eff) + LW'(2));
  assign kx_last   = (WW'(kx_r) == w_eff - WW'(1));
  assign ky_last   = (HH'(ky_r) == h_eff - HH'(1));
  assign fend      = lag_full && kx_last && ky_last;

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    lag_nxt    = lag_r;
    kx_nxt     = kx_r;
    ky_nxt     = ky_r;
    if (size_wr || (processed && fend)) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      lag_nxt    = '0;
      kx_nxt     = '0;
      ky_nxt     = '0;
    end else if (processed) begin
      in_col_nxt = col_last ? '0 : in_col_r + CW'(1);
      if (col_last && !late) in_row_nxt = in_row_r + HH'(1);
      if (!lag_full) lag_nxt = lag_r + LW'(1);
      if (lag_full) begin
        kx_nxt = kx_last ? '0 : kx_r + CW'(1);
        if (kx_last) ky_nxt = ky_r + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      lag_r    <= '0;
      kx_r     <= '0;
      ky_r     <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      lag_r    <= lag_nxt;
      kx_r     <= kx_nxt;
      ky_r     <= ky_nxt;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= processed;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r && s2_prod_r;
      if (o_rdy)  out_v_r <= s3_v_r;
    end
  end

  // output position tags travel with each beat
  logic          s1_prod_r, s1_fend_r, s2_prod_r, s2_fend_r;
  logic [CW-1:0] s1_kx_r, s2_kx_r;
  logic [HW-1:0] s1_ky_r, s2_ky_r;

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_prod_r <= lag_full;
      s1_fend_r <= fend;
      s1_kx_r   <= kx_r;
      s1_ky_r   <= ky_r;
    end
    if (s2_rdy) begin
      s2_prod_r <= s1_prod_r;
      s2_fend_r <= s1_fend_r;
      s2_kx_r   <= s1_kx_r;
      s2_ky_r   <= s1_ky_r;
    end
  end

  // line stores and window
  lw_ctrl_t lw_ctrl;
  win_t     win;

  assign lw_ctrl.s1_en    = s1_rdy;
  assign lw_ctrl.s1_valid = s1_v_r;
  assign lw_ctrl.shift_en = s1_v_r && s2_rdy;

  nbf_line_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_window (
    .clk     (clk),
    .ctrl    (lw_ctrl),
    .rd_addr (in_col_r),
    .pix_in  (in_tdata),
    .win     (win)
  );

  // tap sums over in-frame neighbours, out-of-frame weight goes to the centre
  logic [4:0]       col_ok;
  logic [2:0]       row_ok;
  logic [SUM_W-1:0] tsum [3];
  logic [CWT_W-1:0] cwt;

  always_comb begin
    col_ok[0] = (s2_kx_r >= CW'(2));
    col_ok[1] = (s2_kx_r >= CW'(1));
    col_ok[2] = 1'b1;
    col_ok[3] = (LW'(s2_kx_r) + LW'(1) < LW'(w_eff));
    col_ok[4] = (LW'(s2_kx_r) + LW'(2) < LW'(w_eff));
    row_ok[0] = (s2_ky_r >= HW'(1));
    row_ok[1] = 1'b1;
    row_ok[2] = (HH'(s2_ky_r) + HH'(1) < h_eff);
  end

  always_comb begin : tap_sum
    tap_t tp;
    int   ci;
    int   ri;
    pix_t px;
    for (int c = 0; c < 3; c++) tsum[c] = '0;
    cwt = CWT_W'(16);
    for (int t = 0; t < NUM_TAPS; t++) begin
      tp = recipe_tap(rsel, 3'(t));
      ci = int'(tp.dx) + 2;
      ri = int'(tp.dy) + 1;
      px = win[ri][4 - ci];
      if (col_ok[ci] && row_ok[ri]) begin
        for (int c = 0; c < 3; c++)
          tsum[c] = tsum[c] + SUM_W'(tp.wt) * SUM_W'(px[CH_W*c +: CH_W]);
        cwt = cwt - CWT_W'(tp.wt);
      end
    end
  end

  // stage 3: partial sums, centre weight and centre pixel
  logic [SUM_W-1:0] s3_tsum_r [3];
  logic [CWT_W-1:0] s3_cwt_r;
  pix_t             s3_cpix_r;
  logic             s3_fend_r;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      for (int c = 0; c < 3; c++) s3_tsum_r[c] <= tsum[c];
      s3_cwt_r  <= cwt;
      s3_cpix_r <= win[1][2];
      s3_fend_r <= s2_fend_r;
    end
  end

  // centre term and round half to even
  logic [23:0] rnd_pix;

  always_comb begin : round_blk
    logic [SUM_W-1:0] full;
    logic [7:0]       q;
    logic [3:0]       r;
    logic             inc;
    for (int c = 0; c < 3; c++) begin
      full = s3_tsum_r[c] + SUM_W'(s3_cwt_r) * SUM_W'(s3_cpix_r[CH_W*c +: CH_W]);
      q    = full[11:4];
      r    = full[3:0];
      inc  = (r > 4'd8) || (r == 4'd8 && q[0]);
      rnd_pix[CH_W*c +: CH_W] = q + 8'(inc);
    end
  end

  // output register
  logic [23:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      out_data_r <= rnd_pix;
      out_last_r <= s3_fend_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
